>>> hdl/glce_pkg.sv
`default_nettype none
package glce_pkg;

    localparam int CODE_W  = 12;
    localparam int WIDTH_W = 4;
    localparam int PIX_W   = 8;
    localparam int MCS_W   = 4;
    localparam int NFC_W   = 13;
    localparam int TAG_W   = 8;
    localparam int WORD_W  = TAG_W + PIX_W + 2 * CODE_W;
    localparam logic [15:0] HASH_MULT = 16'd40503;
    localparam logic [WIDTH_W-1:0] MAX_WIDTH = 4'd12;
    localparam logic [MCS_W-1:0] MCS_RESET = 4'd8;
    localparam logic [TAG_W-1:0] TAG_FIRST = 8'd1;
    localparam logic [TAG_W-1:0] TAG_LAST  = 8'd255;

    typedef enum logic [3:0] {
        S_IDLE,
        S_START,
        S_PROBE,
        S_CHECK,
        S_MISS_EMIT,
        S_INSERT,
        S_FULL_EMIT,
        S_FLUSH_EMIT,
        S_EOI_EMIT
    } state_t;

    typedef enum logic [1:0] {
        EMIT_CLEAR,
        EMIT_PREFIX,
        EMIT_EOI
    } emit_sel_t;

    typedef struct packed {
        logic      accept;
        logic      hash_read;
        logic      probe_next;
        logic      take_hit;
        logic      insert;
        logic      restart;
        logic      start;
        logic      finish;
        logic      emit;
        emit_sel_t emit_sel;
        logic      emit_run_end;
    } cmd_t;

    typedef struct packed {
        logic started;
        logic sweeping;
        logic last;
        logic entry_valid;
        logic entry_match;
        logic full_next;
        logic out_free;
    } status_t;

    // clamp the minimum code size into 2..8
    function automatic logic [MCS_W-1:0] eff_mcs(input logic [MCS_W-1:0] v);
        logic [MCS_W-1:0] m;
        m = v;
        if (m < 4'd2) m = 4'd2;
        if (m > 4'd8) m = 4'd8;
        return m;
    endfunction

endpackage
`default_nettype wire

>>> hdl/gif_lzw_code_encoder_top.sv
// GIF LZW code encoder, codes and widths only.
// Input stream: one palette index per transfer on s_tdata, s_tlast marks the
// final pixel of an image. Output stream: one code per transfer, m_tdata holds
// code and code width, m_tlast marks the last code caused by a pixel, m_tuser
// marks end-of-information.
// cfg_wr_en/cfg_wr_data write the minimum code size and restart the stream.
// A pixel is accepted, its hash address read and the probed word checked;
// each extra linear probe of the hash table adds a read and a check, a miss
// emits the prefix code and inserts the entry, a full dictionary then emits
// a clear code, and a last pixel ends with the flush and end codes.
// The first pixel of a stream emits a clear code. Each code waits while the
// output register drains. After reset, and when the 8-bit table epoch wraps,
// a clearing sweep over all HASH_DEPTH table words runs with s_tready low.
// A stalled receiver holds the output register; the encoder waits in its
// emit state until the previous code is taken.
`default_nettype none
module gif_lzw_code_encoder_top #(
    parameter int HASH_DEPTH = 8192,
    parameter int MAX_CODES  = 4096
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [7:0]  s_tdata,   // pixel_index
    input  wire         s_tlast,
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [15:0] m_tdata,   // code [11:0], code_width [15:12]
    output logic        m_tlast,
    output logic        m_tuser,   // stream_end
    input  wire         cfg_wr_en,
    input  wire  [3:0]  cfg_wr_data
);

    glce_pkg::cmd_t    cmd;
    glce_pkg::status_t status;

    glce_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    glce_datapath #(
        .HASH_DEPTH (HASH_DEPTH),
        .MAX_CODES  (MAX_CODES)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .m_tuser     (m_tuser),
        .cmd         (cmd),
        .status      (status)
    );

endmodule
`default_nettype wire

>>> hdl/glce_ctrl.sv
`default_nettype none
module glce_ctrl (
    input  wire               aclk,
    input  wire               aresetn,
    input  wire               s_tvalid,
    output logic              s_tready,
    input  glce_pkg::status_t status,
    output glce_pkg::cmd_t    cmd
);

    glce_pkg::state_t state_reg, state_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= glce_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            glce_pkg::S_IDLE: begin
                if (s_tvalid && !status.sweeping) begin
                    state_next = status.started ? glce_pkg::S_PROBE : glce_pkg::S_START;
                end
            end
            glce_pkg::S_START: begin
                if (status.out_free) begin
                    state_next = status.last ? glce_pkg::S_FLUSH_EMIT : glce_pkg::S_IDLE;
                end
            end
            glce_pkg::S_PROBE: state_next = glce_pkg::S_CHECK;
            glce_pkg::S_CHECK: begin
                if (!status.entry_valid) begin
                    state_next = glce_pkg::S_MISS_EMIT;
                end else if (status.entry_match) begin
                    state_next = status.last ? glce_pkg::S_FLUSH_EMIT : glce_pkg::S_IDLE;
                end
            end
            glce_pkg::S_MISS_EMIT: begin
                if (status.out_free) state_next = glce_pkg::S_INSERT;
            end
            glce_pkg::S_INSERT: begin
                if (status.full_next) begin
                    state_next = glce_pkg::S_FULL_EMIT;
                end else begin
                    state_next = status.last ? glce_pkg::S_FLUSH_EMIT : glce_pkg::S_IDLE;
                end
            end
            glce_pkg::S_FULL_EMIT: begin
                if (status.out_free) begin
                    state_next = status.last ? glce_pkg::S_FLUSH_EMIT : glce_pkg::S_IDLE;
                end
            end
            glce_pkg::S_FLUSH_EMIT: begin
                if (status.out_free) state_next = glce_pkg::S_EOI_EMIT;
            end
            glce_pkg::S_EOI_EMIT: begin
                if (status.out_free) state_next = glce_pkg::S_IDLE;
            end
            default: state_next = glce_pkg::S_IDLE;
        endcase
    end

    // commands
    always_comb begin
        cmd = '0;
        cmd.emit_sel = glce_pkg::EMIT_PREFIX;
        s_tready = 1'b0;
        case (state_reg)
            glce_pkg::S_IDLE: begin
                s_tready   = !status.sweeping;
                cmd.accept = s_tvalid && !status.sweeping;
            end
            glce_pkg::S_START: begin
                cmd.emit         = status.out_free;
                cmd.start        = status.out_free;
                cmd.emit_sel     = glce_pkg::EMIT_CLEAR;
                cmd.emit_run_end = !status.last;
            end
            glce_pkg::S_PROBE: cmd.hash_read = 1'b1;
            glce_pkg::S_CHECK: begin
                cmd.take_hit   = status.entry_valid && status.entry_match;
                cmd.probe_next = status.entry_valid && !status.entry_match;
            end
            glce_pkg::S_MISS_EMIT: begin
                cmd.emit         = status.out_free;
                cmd.emit_sel     = glce_pkg::EMIT_PREFIX;
                cmd.emit_run_end = !status.last && !status.full_next;
            end
            glce_pkg::S_INSERT: cmd.insert = 1'b1;
            glce_pkg::S_FULL_EMIT: begin
                cmd.emit         = status.out_free;
                cmd.restart      = status.out_free;
                cmd.emit_sel     = glce_pkg::EMIT_CLEAR;
                cmd.emit_run_end = !status.last;
            end
            glce_pkg::S_FLUSH_EMIT: begin
                cmd.emit     = status.out_free;
                cmd.emit_sel = glce_pkg::EMIT_PREFIX;
            end
            glce_pkg::S_EOI_EMIT: begin
                cmd.emit         = status.out_free;
                cmd.finish       = status.out_free;
                cmd.emit_sel     = glce_pkg::EMIT_EOI;
                cmd.emit_run_end = 1'b1;
            end
            default: cmd = '0;
        endcase
    end

endmodule
`default_nettype wire

>>> hdl/glce_datapath.sv
`default_nettype none
module glce_datapath #(
    parameter int HASH_DEPTH = 8192,
    parameter int MAX_CODES  = 4096
) (
    input  wire                aclk,
    input  wire                aresetn,
    input  wire  [7:0]         s_tdata,
    input  wire                s_tlast,
    input  wire                cfg_wr_en,
    input  wire  [3:0]         cfg_wr_data,
    output logic               m_tvalid,
    input  wire                m_tready,
    output logic [15:0]        m_tdata,
    output logic               m_tlast,
    output logic               m_tuser,
    input  glce_pkg::cmd_t     cmd,
    output glce_pkg::status_t  status
);

    localparam int HASH_BITS = $clog2(HASH_DEPTH);
    localparam int CW = glce_pkg::CODE_W;
    localparam int WW = glce_pkg::WIDTH_W;

    logic [glce_pkg::MCS_W-1:0]  mcs_reg;
    logic [CW-1:0]               prefix_reg;
    logic [glce_pkg::NFC_W-1:0]  nfc_reg;
    logic [WW-1:0]               width_reg;
    logic                        started_reg;
    logic [glce_pkg::PIX_W-1:0]  px_reg;
    logic                        last_reg;
    logic [glce_pkg::TAG_W-1:0]  epoch_reg;
    logic                        sweep_reg;
    logic [HASH_BITS-1:0]        sweep_addr_reg;
    logic [HASH_BITS-1:0]        probe_addr_reg;
    logic [glce_pkg::WORD_W-1:0] rd_data_reg;
    logic [glce_pkg::WORD_W-1:0] mem [HASH_DEPTH];

    logic                  m_tvalid_reg;
    logic [15:0]           m_tdata_reg;
    logic                  m_tlast_reg;
    logic                  m_tuser_reg;

    logic [glce_pkg::MCS_W-1:0] m_eff, m_cfg;
    logic [CW-1:0]         clear_code, clear_cfg;
    logic [19:0]           key;
    logic [35:0]           prod;
    logic [HASH_BITS-1:0]  rd_addr;
    logic                  mem_we;
    logic [HASH_BITS-1:0]  wr_addr;
    logic [glce_pkg::WORD_W-1:0] wr_data;
    logic [glce_pkg::NFC_W-1:0]  nfc_inc;
    logic [13:0]           pow_w;
    logic [WW-1:0]         width_eoi;
    logic                  out_free;
    logic [CW-1:0]         emit_code;
    logic [WW-1:0]         emit_width;
    logic                  bump;

    assign m_eff      = glce_pkg::eff_mcs(mcs_reg);
    assign m_cfg      = glce_pkg::eff_mcs(cfg_wr_data);
    assign clear_code = CW'(1) << m_eff;
    assign clear_cfg  = CW'(1) << m_cfg;
    assign nfc_inc    = nfc_reg + 1'b1;
    assign pow_w      = 14'(1) << width_reg;
    assign width_eoi  = ({1'b0, nfc_reg} >= pow_w && width_reg < glce_pkg::MAX_WIDTH)
                        ? width_reg + 1'b1 : width_reg;
    assign out_free   = !m_tvalid_reg || m_tready;
    assign bump       = cmd.restart || cmd.finish;

    // hash of the (prefix, pixel) key
    assign key  = {prefix_reg, px_reg};
    assign prod = {16'd0, key} * {20'd0, glce_pkg::HASH_MULT};
    assign rd_addr = cmd.hash_read ? prod[HASH_BITS-1:0] : probe_addr_reg + 1'b1;

    // table write port: sweep or insert
    always_comb begin
        mem_we  = 1'b0;
        wr_addr = probe_addr_reg;
        wr_data = {epoch_reg, px_reg, prefix_reg, nfc_reg[CW-1:0]};
        if (sweep_reg) begin
            mem_we  = 1'b1;
            wr_addr = sweep_addr_reg;
            wr_data = '0;
        end else if (cmd.insert) begin
            mem_we = 1'b1;
        end
    end

    // hash table memory
    always_ff @(posedge aclk) begin
        if (mem_we) mem[wr_addr] <= wr_data;
        rd_data_reg <= mem[rd_addr];
    end

    // probe address follows each hash or probe read
    always_ff @(posedge aclk) begin
        if (cmd.hash_read || cmd.probe_next) probe_addr_reg <= rd_addr;
    end

    // entry checks against the probed word
    always_comb begin
        status.started     = started_reg;
        status.sweeping    = sweep_reg;
        status.last        = last_reg;
        status.entry_valid = rd_data_reg[glce_pkg::WORD_W-1 -: glce_pkg::TAG_W] == epoch_reg;
        status.entry_match = rd_data_reg[2*CW-1:CW] == prefix_reg
                          && rd_data_reg[2*CW+glce_pkg::PIX_W-1:2*CW] == px_reg;
        status.full_next   = nfc_inc >= glce_pkg::NFC_W'(MAX_CODES);
        status.out_free    = out_free;
    end

    // input item latch with masking
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            px_reg   <= s_tdata & glce_pkg::PIX_W'(clear_code - 1'b1);
            last_reg <= s_tlast;
        end
    end

    // coder state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mcs_reg     <= glce_pkg::MCS_RESET;
            prefix_reg  <= '0;
            nfc_reg     <= glce_pkg::NFC_W'((1 << 8) + 2);
            width_reg   <= WW'(9);
            started_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            mcs_reg     <= cfg_wr_data;
            prefix_reg  <= '0;
            nfc_reg     <= glce_pkg::NFC_W'(clear_cfg) + 2'd2;
            width_reg   <= m_cfg + 1'b1;
            started_reg <= 1'b0;
        end else begin
            if (cmd.start) begin
                started_reg <= 1'b1;
                prefix_reg  <= {4'd0, px_reg};
            end
            if (cmd.take_hit) prefix_reg <= rd_data_reg[CW-1:0];
            if (cmd.insert) begin
                nfc_reg    <= nfc_inc;
                prefix_reg <= {4'd0, px_reg};
                if ({1'b0, nfc_inc} > pow_w && width_reg < glce_pkg::MAX_WIDTH)
                    width_reg <= width_reg + 1'b1;
            end
            if (bump) begin
                nfc_reg   <= glce_pkg::NFC_W'(clear_code) + 2'd2;
                width_reg <= m_eff + 1'b1;
            end
            if (cmd.finish) begin
                started_reg <= 1'b0;
                prefix_reg  <= '0;
            end
        end
    end

    // table epoch and clearing sweep
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            epoch_reg      <= glce_pkg::TAG_FIRST;
            sweep_reg      <= 1'b1;
            sweep_addr_reg <= '0;
        end else if (sweep_reg) begin
            sweep_addr_reg <= sweep_addr_reg + 1'b1;
            if (sweep_addr_reg == HASH_BITS'(HASH_DEPTH - 1)) begin
                sweep_reg <= 1'b0;
                epoch_reg <= glce_pkg::TAG_FIRST;
            end
        end else if (cfg_wr_en || bump) begin
            if (epoch_reg == glce_pkg::TAG_LAST) begin
                sweep_reg      <= 1'b1;
                sweep_addr_reg <= '0;
            end else begin
                epoch_reg <= epoch_reg + 1'b1;
            end
        end
    end

    // result selection
    always_comb begin
        case (cmd.emit_sel)
            glce_pkg::EMIT_CLEAR: begin
                emit_code  = clear_code;
                emit_width = width_reg;
            end
            glce_pkg::EMIT_EOI: begin
                emit_code  = clear_code + 1'b1;
                emit_width = width_eoi;
            end
            default: begin
                emit_code  = prefix_reg;
                emit_width = width_reg;
            end
        endcase
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            m_tdata_reg <= {emit_width, emit_code};
            m_tlast_reg <= cmd.emit_run_end;
            m_tuser_reg <= cmd.emit_sel == glce_pkg::EMIT_EOI;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tuser  = m_tuser_reg;

endmodule
`default_nettype wire

>>> hdl/glce_checker.sv
`default_nettype none
module glce_checker (
    input wire        aclk,
    input wire        aresetn,
    input wire        s_tready,
    input wire        m_tvalid,
    input wire        m_tready,
    input wire [15:0] m_tdata,
    input wire        m_tlast,
    input wire        m_tuser
);

    // clearing sweep blocks input right after reset
    a_sweep_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !s_tready)
        else $error("input taken during reset sweep");

    // end-of-information always closes the run
    a_eoi_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tlast)
        else $error("end code without run end");

    // code width within 3..12
    a_width: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[15:12] >= 4'd3 && m_tdata[15:12] <= 4'd12))
        else $error("code width out of range");

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result changed");

endmodule

bind gif_lzw_code_encoder_top glce_checker u_glce_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);
`default_nettype wire
